FILE: rtl/core/tlrq_pkg.sv
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types and constants of the three-level ready queue: command, status
// and level codes, register indexes, entry layout and address helpers.
// ----------------------------------------------------------------------------
package tlrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_LEVELS  = 3;

	localparam int ID_W    = 8;
	localparam int PRIO_W  = 8;
	localparam int KEY_W   = 16;
	localparam int ENTRY_W = KEY_W + ID_W;

	localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
	localparam int AW        = $clog2(RAM_DEPTH);

	localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	// commands
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// levels
	localparam logic [1:0] LEVEL_BURST = 2'd0;
	localparam logic [1:0] LEVEL_PRIO  = 2'd1;
	localparam logic [1:0] LEVEL_FIFO  = 2'd2;

	// register indexes and reset values
	localparam logic REG_LOW_LIMIT  = 1'b0;
	localparam logic REG_HIGH_LIMIT = 1'b1;
	localparam logic [PRIO_W-1:0] LOW_LIMIT_RST  = PRIO_W'(50);
	localparam logic [PRIO_W-1:0] HIGH_LIMIT_RST = PRIO_W'(100);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_FETCH = 6'b000100,
		S_WALK  = 6'b001000,
		S_PLACE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	// ring position of a logical slot, then offset into the level's region
	function automatic logic [AW-1:0] phys_addr(input logic [1:0] lvl,
		input logic [IDX_W-1:0] head, input logic [IDX_W-1:0] idx);
		logic [IDX_W:0] sum;
		logic [IDX_W:0] wrapped;
		sum = {1'b0, head} + {1'b0, idx};
		wrapped = (sum >= DEPTH_WIDE) ? (sum - DEPTH_WIDE) : sum;
		return AW'(lvl) * AW'(QUEUE_DEPTH) + AW'(wrapped);
	endfunction

endpackage

FILE: rtl/core/tlrq_ram.sv
// ----------------------------------------------------------------------------
// tlrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/three_level_ready_queue.sv
// ----------------------------------------------------------------------------
// three_level_ready_queue
// Ready-queue engine: three bounded levels of thread ids, served burst level
// first, then priority level, then first-in-first-out level.
// ----------------------------------------------------------------------------
// one word in is worked on at a time and the block stalls its input meanwhile,
// also while the previous result word is still held by the receiver; the
// sequencer is built around a single shared key comparator and the one read /
// one write port of the entry ram. a remove or peek does one registered read
// of the level head, and skips that fetch when every level is empty. an insert
// into the fifo level, into an empty sorted level, or into a full level needs
// no walk. an insert into a sorted level walks back from the tail one entry
// per cycle, moving each entry that the new key beats up one slot. each level
// is a ring in its own region of the ram with a head pointer, so a remove just
// advances the head. a finished word waits in the output register, and the
// block takes the next word meanwhile. there is no clearing pass: only slots
// below a level's count are ever read.
// ----------------------------------------------------------------------------
module three_level_ready_queue
	import tlrq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input words
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [KEY_W-1:0]  burst_time,
	// result words
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   chosen_id,
	output logic [1:0]        level,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// level limits
	logic [PRIO_W-1:0] low_q;
	logic [PRIO_W-1:0] high_q;

	// sequencer and captured word
	state_t            state_q;
	logic              ins_q;
	logic              take_q;
	logic              none_q;
	logic [1:0]        lvl_q;
	logic [ID_W-1:0]   id_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  idx_q;

	// per-level occupancy and ring head
	logic [CNT_W-1:0]  cnt_q  [NUM_LEVELS];
	logic [IDX_W-1:0]  head_q [NUM_LEVELS];

	// staged result and output register
	logic [1:0]        res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [1:0]        res_level_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [1:0]        out_level_q;

	logic              accept;
	logic              is_insert;
	logic [1:0]        ins_lvl;
	logic [1:0]        srv_lvl;
	logic              all_empty;
	logic [CNT_W-1:0]  cnt_sel;
	logic [CNT_W-1:0]  cnt_dec;
	logic [IDX_W-1:0]  head_sel;
	logic              lvl_full;
	logic              direct_put;
	logic              goes_before;
	logic [IDX_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  idx_dec;
	logic [IDX_W-1:0]  head_next;
	logic              out_load;
	entry_t            rd_entry;
	entry_t            new_entry;

	// ram port
	logic              ram_we;
	logic [IDX_W-1:0]  w_idx;
	logic [IDX_W-1:0]  r_idx;
	entry_t            ram_wdata;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HIGH_LIMIT) ? {24'd0, high_q} : {24'd0, low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_LIMIT_RST;
			high_q <= HIGH_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			// only paddr[2] decodes, low bits are ignored
			if (paddr[2] == REG_LOW_LIMIT) begin
				low_q <= pwdata[PRIO_W-1:0];
			end else begin
				high_q <= pwdata[PRIO_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- intake
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign is_insert = (cmd == CMD_INSERT);

	// low limit is tested first, so crossed limits leave the middle level unused
	assign ins_lvl = (priority_req < low_q)  ? LEVEL_FIFO :
	                 (priority_req < high_q) ? LEVEL_PRIO : LEVEL_BURST;

	// serve order: burst level, then priority level, then fifo level
	assign all_empty = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);
	assign srv_lvl   = (cnt_q[0] != '0) ? LEVEL_BURST :
	                   (cnt_q[1] != '0) ? LEVEL_PRIO  : LEVEL_FIFO;

	// ---------------------------------------------------------------- datapath
	assign cnt_sel    = cnt_q[lvl_q];
	assign head_sel   = head_q[lvl_q];
	assign cnt_dec    = cnt_sel - 1'b1;
	assign lvl_full   = (cnt_sel == DEPTH_CNT);
	// fifo appends and first entries of a sorted level need no walk
	assign direct_put = (lvl_q == LEVEL_FIFO) || (cnt_sel == '0);
	assign idx_inc    = idx_q + 1'b1;
	assign idx_dec    = idx_q - 1'b1;
	assign head_next  = (head_sel == LAST_IDX) ? '0 : (head_sel + 1'b1);

	// finished word moves into the output register once that register is free
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign rd_entry      = entry_t'(ram_rdata);
	assign new_entry.key = key_q;
	assign new_entry.id  = id_q;

	// the shared comparator: strict, so equal keys keep arrival order
	assign goes_before = (lvl_q == LEVEL_BURST) ? (key_q < rd_entry.key)
	                                            : (key_q > rd_entry.key);

	always_comb begin
		ram_we    = 1'b0;
		w_idx     = '0;
		r_idx     = '0;
		ram_wdata = new_entry;
		case (state_q)
			S_START: begin
				if (ins_q) begin
					if (!lvl_full && direct_put) begin
						ram_we = 1'b1;
						w_idx  = cnt_sel[IDX_W-1:0];
					end
					// tail of the sorted level, first compare
					r_idx = cnt_dec[IDX_W-1:0];
				end
			end
			S_WALK: begin
				ram_we = 1'b1;
				w_idx  = idx_inc;
				if (goes_before) begin
					// shift this entry up one slot, fetch the next one down
					ram_wdata = rd_entry;
					r_idx     = idx_dec;
				end
			end
			S_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_waddr = phys_addr(lvl_q, head_sel, w_idx);
	assign ram_raddr = phys_addr(lvl_q, head_sel, r_idx);

	tlrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ins_q        <= 1'b0;
			take_q       <= 1'b0;
			none_q       <= 1'b0;
			lvl_q        <= LEVEL_BURST;
			id_q         <= '0;
			key_q        <= '0;
			idx_q        <= '0;
			res_status_q <= STATUS_OK;
			res_id_q     <= '0;
			res_level_q  <= LEVEL_BURST;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_id_q     <= '0;
			out_level_q  <= LEVEL_BURST;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			// output register loads a finished word, else drains on its own
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_id_q     <= res_id_q;
				out_level_q  <= res_level_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ins_q   <= is_insert;
						take_q  <= (cmd == CMD_REMOVE);
						none_q  <= !is_insert && all_empty;
						lvl_q   <= is_insert ? ins_lvl : srv_lvl;
						id_q    <= thread_id;
						key_q   <= (ins_lvl == LEVEL_BURST) ? burst_time
						                                    : {8'd0, priority_req};
						state_q <= S_START;
					end
				end
				S_START: begin
					if (ins_q) begin
						res_status_q <= lvl_full ? STATUS_FULL : STATUS_OK;
						res_id_q     <= id_q;
						res_level_q  <= lvl_q;
						if (lvl_full) begin
							state_q <= S_DONE;
						end else if (direct_put) begin
							cnt_q[lvl_q] <= cnt_sel + 1'b1;
							state_q      <= S_DONE;
						end else begin
							idx_q   <= cnt_dec[IDX_W-1:0];
							state_q <= S_WALK;
						end
					end else if (none_q) begin
						res_status_q <= STATUS_EMPTY;
						res_id_q     <= '0;
						res_level_q  <= LEVEL_BURST;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					// head entry arrives from the ram this cycle
					res_status_q <= STATUS_OK;
					res_id_q     <= rd_entry.id;
					res_level_q  <= lvl_q;
					if (take_q) begin
						head_q[lvl_q] <= head_next;
						cnt_q[lvl_q]  <= cnt_dec;
					end
					state_q <= S_DONE;
				end
				S_WALK: begin
					if (goes_before) begin
						if (idx_q == '0) begin
							state_q <= S_PLACE;
						end else begin
							idx_q <= idx_dec;
						end
					end else begin
						cnt_q[lvl_q] <= cnt_sel + 1'b1;
						state_q      <= S_DONE;
					end
				end
				S_PLACE: begin
					cnt_q[lvl_q] <= cnt_sel + 1'b1;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign chosen_id = out_id_q;
	assign level     = out_level_q;

	// ---------------------------------------------------------------- checks
	// no level ever holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= DEPTH_CNT) && (cnt_q[1] <= DEPTH_CNT) && (cnt_q[2] <= DEPTH_CNT))
		else $error("level count above queue depth");

	// occupancy only moves while a word is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (cnt_q[0] == $past(cnt_q[0])) &&
			(cnt_q[1] == $past(cnt_q[1])) && (cnt_q[2] == $past(cnt_q[2])))
		else $error("level count changed while idle");

	// a new result word is only loaded when the sequencer finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word appeared outside done state");

	// an empty report is only given when no level holds anything
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) && !ins_q && none_q |->
			(cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0))
		else $error("empty reported with entries queued");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-level ready queue. A directed table walks
// the empty, edge and ordering cases first. Random traffic follows, in
// alternating fill and drain runs under several limit settings, so that every
// level fills up and empties out. Each accepted word is run through a
// scheduler model, and each result word is checked against it or its typed row.
// ----------------------------------------------------------------------------
module tb
	import tlrq_pkg::*;
();

	localparam logic [1:0] CMD_CODE3 = 2'd3;   // undefined code, acts as peek
	localparam int N_DIR       = 25;
	localparam int N_SEG       = 9;
	localparam int SEG_WORDS   = 167;
	localparam int SETTLE      = QUEUE_DEPTH + 8;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] chosen;
		logic [1:0] lvl;
	} sched_result_t;

	typedef struct packed {
		logic [1:0]    c;
		logic [7:0]    tid;
		logic [7:0]    pr;
		logic [15:0]   b;
		logic          typed;
		sched_result_t res;
	} dir_row_t;

	// dut ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_INSERT;
	logic [7:0]  thread_id = '0;
	logic [7:0]  priority_req = '0;
	logic [15:0] burst_time = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  chosen_id;
	logic [1:0]  level;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// scheduler model state: sorted levels hold {key, id}, fifo level holds ids
	entry_t        burst_lvl[$];
	entry_t        prio_lvl[$];
	logic [7:0]    fifo_lvl[$];
	logic [7:0]    lim_low = LOW_LIMIT_RST;
	logic [7:0]    lim_high = HIGH_LIMIT_RST;

	sched_result_t pending_dispatch[$];   // results still owed by the dut
	int            mismatches = 0;
	int            send_idle_pct = 23;
	int            recv_stall_pct = 60;
	bit            hold_req = 1'b0;

	dir_row_t      dir_tab [0:N_DIR-1];

	three_level_ready_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.burst_time   (burst_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.chosen_id    (chosen_id),
		.level        (level),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// next dispatch decision for one accepted word, updates the level model
	function automatic sched_result_t predict_dispatch(logic [1:0] c, logic [7:0] tid,
		logic [7:0] pr, logic [15:0] b);
		sched_result_t r;
		int pos;
		int fill;
		r = '{STATUS_OK, 8'h00, LEVEL_BURST};
		if (c == CMD_INSERT) begin
			r.chosen = tid;
			// low limit is tested first, so crossed limits starve the priority level
			if (pr < lim_low)
				r.lvl = LEVEL_FIFO;
			else if (pr < lim_high)
				r.lvl = LEVEL_PRIO;
			else
				r.lvl = LEVEL_BURST;
			case (r.lvl)
				LEVEL_BURST: fill = burst_lvl.size();
				LEVEL_PRIO:  fill = prio_lvl.size();
				default:     fill = fifo_lvl.size();
			endcase
			if (fill >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
			end else if (r.lvl == LEVEL_BURST) begin
				// shortest burst first, ties stay in arrival order
				pos = 0;
				while (pos < burst_lvl.size() && b >= burst_lvl[pos].key)
					pos++;
				burst_lvl.insert(pos, entry_t'{key: b, id: tid});
			end else if (r.lvl == LEVEL_PRIO) begin
				// highest priority first, ties stay in arrival order
				pos = 0;
				while (pos < prio_lvl.size() && pr <= prio_lvl[pos].key[7:0])
					pos++;
				prio_lvl.insert(pos, entry_t'{key: {8'h00, pr}, id: tid});
			end else begin
				fifo_lvl.push_back(tid);
			end
		end else if (burst_lvl.size() != 0) begin
			r.chosen = burst_lvl[0].id;
			if (c == CMD_REMOVE)
				void'(burst_lvl.pop_front());
		end else if (prio_lvl.size() != 0) begin
			r.lvl = LEVEL_PRIO;
			r.chosen = prio_lvl[0].id;
			if (c == CMD_REMOVE)
				void'(prio_lvl.pop_front());
		end else if (fifo_lvl.size() != 0) begin
			r.lvl = LEVEL_FIFO;
			r.chosen = fifo_lvl[0];
			if (c == CMD_REMOVE)
				void'(fifo_lvl.pop_front());
		end else begin
			r.status = STATUS_EMPTY;
		end
		return r;
	endfunction

	// offer one word, wait for the handshake, then log what it should produce
	task automatic send_word(logic [1:0] c, logic [7:0] tid, logic [7:0] pr,
		logic [15:0] b, logic typed, sched_result_t typed_res);
		sched_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		thread_id    <= tid;
		priority_req <= pr;
		burst_time   <= b;
		do
			@(posedge clk);
		while (in_stall);
		r = predict_dispatch(c, tid, pr, b);
		pending_dispatch.push_back(typed ? typed_res : r);
	endtask

	// drop valid, let every owed result come out, then give the block time to settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_dispatch.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write then read back, only while the block is idle
	task automatic reg_set(logic idx, logic [7:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'h0, v}) begin
			$display("%0t: register %0d readback, expected %0h actual %0h",
				$time, idx, v, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_LOW_LIMIT)
			lim_low = v;
		else
			lim_high = v;
	endtask

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// result side: random stall, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// result checker against the oldest owed result
	always @(posedge clk) begin
		sched_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_dispatch.size() == 0) begin
				$display("%0t: unexpected result word, actual status %0d id %0h level %0d",
					$time, status, chosen_id, level);
				mismatches++;
			end else begin
				want = pending_dispatch.pop_front();
				check_field("status", 8'(want.status), 8'(status));
				check_field("chosen_id", want.chosen, chosen_id);
				check_field("level", 8'(want.lvl), 8'(level));
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0]  seg_low [0:N_SEG-1];
		logic [7:0]  seg_high [0:N_SEG-1];
		logic [1:0]  c;
		logic [7:0]  tid;
		logic [7:0]  pr;
		logic [15:0] b;
		int          run_left;
		bit          filling;
		sched_result_t empty_res;

		empty_res = '{STATUS_EMPTY, 8'h00, LEVEL_BURST};
		// limit settings per random segment, extremes and crossed limits among them
		seg_low  = '{8'd50,  8'd0, 8'd255, 8'd0,   8'd200, 8'd255, 8'd30,  8'd0, 8'd50};
		seg_high = '{8'd100, 8'd0, 8'd255, 8'd255, 8'd30,  8'd0,   8'd180, 8'd0, 8'd100};

		// directed table under reset limits; typed rows carry their own result
		dir_tab = '{
			// empty queue on remove, peek and the undefined code
			'{CMD_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, empty_res},
			'{CMD_PEEK,   8'h00, 8'h00, 16'h0000, 1'b1, empty_res},
			'{CMD_CODE3,  8'hA5, 8'h5A, 16'h5AA5, 1'b1, empty_res},
			// level boundaries at 50 and 100, field extremes
			'{CMD_INSERT, 8'hFF, 8'd0,   16'hFFFF, 1'b1, '{STATUS_OK, 8'hFF, LEVEL_FIFO}},
			'{CMD_INSERT, 8'h00, 8'd49,  16'h0000, 1'b1, '{STATUS_OK, 8'h00, LEVEL_FIFO}},
			'{CMD_INSERT, 8'h11, 8'd50,  16'h1234, 1'b1, '{STATUS_OK, 8'h11, LEVEL_PRIO}},
			'{CMD_INSERT, 8'h12, 8'd99,  16'h0000, 1'b1, '{STATUS_OK, 8'h12, LEVEL_PRIO}},
			'{CMD_INSERT, 8'h13, 8'd99,  16'hFFFF, 1'b1, '{STATUS_OK, 8'h13, LEVEL_PRIO}},
			'{CMD_INSERT, 8'h21, 8'd100, 16'hFFFF, 1'b1, '{STATUS_OK, 8'h21, LEVEL_BURST}},
			'{CMD_INSERT, 8'h22, 8'd255, 16'h0000, 1'b1, '{STATUS_OK, 8'h22, LEVEL_BURST}},
			'{CMD_INSERT, 8'h23, 8'd128, 16'h0000, 1'b1, '{STATUS_OK, 8'h23, LEVEL_BURST}},
			'{CMD_INSERT, 8'h24, 8'd170, 16'h8000, 1'b1, '{STATUS_OK, 8'h24, LEVEL_BURST}},
			// peek does not consume, code 3 behaves as peek
			'{CMD_PEEK,   8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_CODE3,  8'hFF, 8'hFF, 16'hFFFF, 1'b0, sched_result_t'('0)},
			// drain burst level, then priority level, then fifo level
			'{CMD_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h5A, 8'hA5, 16'h0F0F, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'hFF, 8'h00, 16'hFFFF, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'hFF, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			'{CMD_REMOVE, 8'h00, 8'h00, 16'h0000, 1'b0, sched_result_t'('0)},
			// everything served, back to empty
			'{CMD_REMOVE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, empty_res}
		};

		// reset released on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_word(dir_tab[i].c, dir_tab[i].tid, dir_tab[i].pr, dir_tab[i].b,
				dir_tab[i].typed, dir_tab[i].res);

		for (int seg = 0; seg < N_SEG; seg++) begin
			wait_idle();
			if (seg == 7) begin
				seg_low[seg]  = 8'($urandom);
				seg_high[seg] = 8'($urandom);
			end
			reg_set(REG_LOW_LIMIT, seg_low[seg]);
			reg_set(REG_HIGH_LIMIT, seg_high[seg]);
			// pacing: sender light / receiver heavy, then swapped, then none
			case (seg / 3)
				0: begin
					send_idle_pct  = 23;
					recv_stall_pct = 60;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 23;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			// long receiver hold-off so the block backs up and stalls its input
			if (seg == 7)
				hold_req = 1'b1;
			run_left = 0;
			filling  = 1'b1;
			for (int k = 0; k < SEG_WORDS; k++) begin
				// alternate fill and drain runs so levels hit both full and empty
				if (run_left == 0) begin
					run_left = $urandom_range(15, 40);
					filling  = !filling;
				end
				run_left--;
				tid = 8'($urandom);
				b   = 16'($urandom);
				pr  = 8'($urandom);
				if ($urandom_range(99) < 8) begin
					// noise: any code, any fields
					c = 2'($urandom_range(0, 3));
				end else if ($urandom_range(99) < (filling ? 80 : 25)) begin
					c = CMD_INSERT;
					case ($urandom_range(0, 6))
						0: pr = lim_low;
						1: pr = lim_low - 8'd1;
						2: pr = lim_high;
						3: pr = lim_high - 8'd1;
						default: ;
					endcase
					// small bursts make equal keys common
					case ($urandom_range(0, 3))
						0: b = 16'hFFFF;
						1, 2: b = 16'($urandom_range(0, 3));
						default: ;
					endcase
				end else begin
					c = ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_REMOVE;
				end
				send_word(c, tid, pr, b, 1'b0, sched_result_t'('0));
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
